@@ rtl/wmpc_pkg.sv @@
// wmpc_pkg: shared types and constants of the wav to mono pcm16 converter
// sample format codes and configuration register indexes; no dependencies
`default_nettype none

package wmpc_pkg;

  // sample format of the data chunk
  typedef enum logic [1:0] {
    KIND_PCM16   = 2'd0,
    KIND_PCM24   = 2'd1,
    KIND_PCM32   = 2'd2,
    KIND_FLOAT32 = 2'd3
  } sample_kind_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SAMPLE_KIND   = 2'd0;
  localparam cfg_idx_t CFG_CHANNEL_COUNT = 2'd1;
  localparam cfg_idx_t CFG_DATA_SIZE     = 2'd2;

  localparam int unsigned CFG_DATA_W = 32;

  // widest frame is 4 bytes times 2 channels
  localparam int unsigned POS_W   = 3;
  localparam int unsigned FRAME_W = 4;

endpackage

`default_nettype wire

@@ rtl/wav_to_mono_pcm16_converter_core.sv @@
// wav_to_mono_pcm16_converter_core: wav data-chunk bytes in, left-channel int16 samples out
// depends on wmpc_pkg for format codes and register indexes
//
//   channel | direction | tdata                | tuser | tlast
//   in_     | slave     | [7:0] data_byte      | -     | -
//   out_    | master    | [15:0] sample        | -     | last
//   cfg_    | write     | [31:0] register data | -     | -
//
// one byte accepted per cycle while in_tready is high; a completed frame goes to the output as follows:
// the byte stage assembles the left word, the conversion stage turns it into a sample
// and holds it in the output register. the float path (multiply by 65535, round, shift)
// sits entirely in the conversion stage. rst_n is synchronous: counts and frame state
// clear and config registers take their reset values. in_tready drops only when both stages
// hold a sample and the output is stalled.
`default_nettype none

module wav_to_mono_pcm16_converter_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input byte stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [7:0] data_byte
  // sample stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [15:0]                       out_tdata,  // [15:0] sample
  output logic                              out_tlast,  // last
  // configuration writes
  input  wire logic                         cfg_wr_en,
  input  wire logic [wmpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wmpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  wmpc_pkg::sample_kind_t sample_kind_r;
  logic [1:0]             channel_count_r;
  logic [31:0]            data_size_r;

  // byte stage state
  logic [31:0]                  byte_count_r, byte_count_nxt;
  logic [wmpc_pkg::POS_W-1:0]   frame_pos_r, frame_pos_nxt;
  logic [31:0]                  left_bytes_r, left_bytes_nxt;

  // assembled word waiting for conversion
  logic                   s1_valid_r, s1_valid_nxt;
  logic [31:0]            s1_word_r;
  wmpc_pkg::sample_kind_t s1_kind_r;
  logic                   s1_last_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r;
  logic        out_last_r;

  logic                           in_fire, step, frame_done, s2_load;
  logic [2:0]                     bps;
  logic [wmpc_pkg::FRAME_W-1:0]   frame_len;
  logic [31:0]                    left_merged;
  logic [31:0]                    count_inc;
  logic [15:0]                    sample_cvt;

  // exact trunc(32767.5*x - 0.5) for single precision bits, saturated
  function automatic logic [15:0] float_to_s16(input logic [31:0] f);
    logic        neg;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] mant;
    logic [39:0] n;
    logic [5:0]  shamt;
    logic [40:0] half;
    logic [41:0] sum;
    logic [41:0] shifted;
    logic [16:0] mag;
    logic [15:0] res;
    neg   = f[31];
    e     = f[30:23];
    m     = f[22:0];
    mant  = {1'b1, m};
    n     = {mant, 16'd0} - {16'd0, mant};
    // only used for exponents 110..126, giving 41 down to 25
    shamt = 6'(8'd151 - e);
    half  = 41'd1 << (shamt - 6'd1);
    if (neg) begin
      sum = {2'b00, n} + {1'b0, half};
    end else begin
      sum = {2'b00, n} - {1'b0, half};
    end
    shifted = sum >> shamt;
    mag     = shifted[16:0];
    if (e == 8'hFF && m != 23'd0) begin
      res = 16'd0;                       // nan
    end else if (e >= 8'd127) begin
      res = neg ? 16'h8000 : 16'h7FFF;   // magnitude one or more
    end else if (e <= 8'd109) begin
      res = 16'd0;                       // below half an lsb, zero and denormals too
    end else if (!neg) begin
      if (sum[41]) begin
        res = 16'd0;
      end else if (mag > 17'd32767) begin
        res = 16'h7FFF;
      end else begin
        res = mag[15:0];
      end
    end else begin
      if (mag > 17'd32768) begin
        res = 16'h8000;
      end else begin
        res = 16'(17'd0 - mag);
      end
    end
    return res;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_kind_r   <= wmpc_pkg::KIND_PCM16;
      channel_count_r <= 2'd1;
      data_size_r     <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wmpc_pkg::CFG_SAMPLE_KIND:   sample_kind_r   <= wmpc_pkg::sample_kind_t'(cfg_wdata[1:0]);
        wmpc_pkg::CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[1:0];
        wmpc_pkg::CFG_DATA_SIZE:     data_size_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // frame geometry
  always_comb begin
    unique case (sample_kind_r)
      wmpc_pkg::KIND_PCM16:   bps = 3'd2;
      wmpc_pkg::KIND_PCM24:   bps = 3'd3;
      wmpc_pkg::KIND_PCM32:   bps = 3'd4;
      wmpc_pkg::KIND_FLOAT32: bps = 3'd4;
      default:                bps = 3'd4;
    endcase
    // zero channels counts as one, three as two
    if (channel_count_r[1]) begin
      frame_len = {bps, 1'b0};
    end else begin
      frame_len = {1'b0, bps};
    end
  end

  // handshakes
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_fire   = in_tvalid && in_tready;
  // bytes past the data size are taken and dropped
  assign step      = in_fire && (byte_count_r < data_size_r);
  assign count_inc = byte_count_r + 32'd1;
  assign frame_done = (({1'b0, frame_pos_r} + 4'd1) >= frame_len);

  // place the byte into the left word while inside the first channel
  always_comb begin
    left_merged = left_bytes_r;
    if ({1'b0, frame_pos_r} < {1'b0, bps}) begin
      for (int i = 0; i < 4; i++) begin
        if (frame_pos_r[1:0] == 2'(i)) begin
          left_merged[i*8 +: 8] = in_tdata;
        end
      end
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    frame_pos_nxt  = frame_pos_r;
    left_bytes_nxt = left_bytes_r;
    if (step) begin
      byte_count_nxt = count_inc;
      if (frame_done) begin
        frame_pos_nxt  = '0;
        left_bytes_nxt = 32'd0;
      end else begin
        frame_pos_nxt  = frame_pos_r + 3'd1;
        left_bytes_nxt = left_merged;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    if (step && frame_done) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 32'd0;
      frame_pos_r  <= '0;
      left_bytes_r <= 32'd0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      frame_pos_r  <= frame_pos_nxt;
      left_bytes_r <= left_bytes_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload of the assembled word
  always_ff @(posedge clk) begin
    if (step && frame_done) begin
      s1_word_r <= left_merged;
      s1_kind_r <= sample_kind_r;
      s1_last_r <= (count_inc == data_size_r);
    end
  end

  // conversion stage
  always_comb begin
    unique case (s1_kind_r)
      wmpc_pkg::KIND_PCM16:   sample_cvt = s1_word_r[15:0];
      wmpc_pkg::KIND_PCM24:   sample_cvt = s1_word_r[23:8];
      wmpc_pkg::KIND_PCM32:   sample_cvt = s1_word_r[31:16];
      wmpc_pkg::KIND_FLOAT32: sample_cvt = float_to_s16(s1_word_r);
      default:                sample_cvt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_sample_r <= sample_cvt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

  // checks
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |-> (!out_valid_r || out_tready))
    else $error("conversion stage overwrote a pending sample");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_dropped_byte_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !step) |=> $stable(byte_count_r) && $stable(frame_pos_r))
    else $error("byte past data size changed state");

  a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && frame_done) |=> (frame_pos_r == '0) && s1_valid_r)
    else $error("frame end did not rewind position");

  a_held_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> $stable(s1_word_r) && $stable(s1_last_r))
    else $error("held word changed while waiting");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for wav_to_mono_pcm16_converter_core, byte stream in, int16 samples out
// relies on wmpc_pkg for sample format codes and register indexes; needs nothing but the rtl
// a local model of the converter predicts every sample, random idling covers both handshakes
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 4;
  localparam int PHASE_ITEMS  = 320;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } pcm_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = 8'h00;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;
  logic                            out_tlast;
  logic                            cfg_wr_en = 1'b0;
  logic [wmpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wmpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // converter state as the bench sees it, reset values included
  wmpc_pkg::sample_kind_t cur_kind = wmpc_pkg::KIND_PCM16;
  logic [1:0]   cur_chans = 2'd1;
  logic [31:0]  cur_size = '0;
  logic [31:0]  bytes_seen = '0;
  logic [2:0]   frame_pos = '0;
  logic [31:0]  left_word = '0;

  pcm_result_t expected_samples[$];
  logic [31:0] stream_word = '0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          counted_items = 0;
  int          samples_checked = 0;
  int          mismatches = 0;
  int          cycles = 0;

  wav_to_mono_pcm16_converter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles,
               expected_samples.size());
      $display("wav_to_mono_pcm16_converter_core: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("error at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic int unsigned sample_bytes(input wmpc_pkg::sample_kind_t k);
    case (k)
      wmpc_pkg::KIND_PCM16: return 2;
      wmpc_pkg::KIND_PCM24: return 3;
      default:              return 4;
    endcase
  endfunction

  function automatic int unsigned channel_total(input logic [1:0] c);
    if (c == 2'd0) return 1;
    if (c == 2'd3) return 2;
    return 32'(c);
  endfunction

  // exact trunc(32767.5*x - 0.5) with saturation, nan and tiny values give zero
  function automatic logic [15:0] float_to_pcm16(input logic [31:0] f);
    logic        neg;
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] n, half, mag;
    int unsigned sh;
    neg = f[31];
    e = f[30:23];
    m = f[22:0];
    if (e == 8'hFF && m != '0) return 16'h0000;
    if (e >= 8'd127) return neg ? 16'h8000 : 16'h7FFF;
    if (e == 8'd0) return 16'h0000;
    sh = 150 - e;
    if (sh >= 41) return 16'h0000;
    n = 64'd65535 * {40'd0, 1'b1, m};
    half = 64'd1 << sh;
    if (!neg) begin
      if (n < half) return 16'h0000;
      mag = (n - half) >> (sh + 1);
      if (mag > 64'd32767) mag = 64'd32767;
      return mag[15:0];
    end
    mag = (n + half) >> (sh + 1);
    if (mag > 64'd32768) mag = 64'd32768;
    mag = ~mag + 64'd1;
    return mag[15:0];
  endfunction

  // advance the local converter by one accepted byte; 1 when a sample is due
  function automatic bit absorb_byte(input logic [7:0] b, output pcm_result_t r);
    int unsigned bps, frame_len, pos;
    r = '0;
    if (bytes_seen >= cur_size) return 0;
    bps = sample_bytes(cur_kind);
    frame_len = bps * channel_total(cur_chans);
    pos = 32'(frame_pos);
    bytes_seen++;
    if (pos < bps) left_word[pos*8 +: 8] = b;
    // a shorter frame after a mid-frame reconfiguration ends on the next byte
    if (pos + 1 < frame_len) begin
      frame_pos = 3'(pos + 1);
      return 0;
    end
    frame_pos = '0;
    case (cur_kind)
      wmpc_pkg::KIND_PCM16: r.sample = left_word[15:0];
      wmpc_pkg::KIND_PCM24: r.sample = left_word[23:8];
      wmpc_pkg::KIND_PCM32: r.sample = left_word[31:16];
      default:              r.sample = float_to_pcm16(left_word);
    endcase
    left_word = '0;
    r.last = (bytes_seen == cur_size);
    return 1;
  endfunction

  always @(posedge clk) begin
    pcm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %h last %b with none expected", out_tdata, out_tlast));
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_tdata !== want.sample)
          report_mismatch($sformatf("sample %h, expected %h", out_tdata, want.sample));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    pcm_result_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    if (bytes_seen < cur_size) counted_items++;
    if (absorb_byte(b, r)) expected_samples.push_back(r);
  endtask

  // quiet the input, let every sample out and the pipeline empty
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic configure(input wmpc_pkg::sample_kind_t k, input logic [1:0] ch,
                           input logic [31:0] size);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= wmpc_pkg::CFG_SAMPLE_KIND;
    cfg_wdata <= {30'd0, k};
    @(posedge clk);
    cur_kind = k;
    cfg_index <= wmpc_pkg::CFG_CHANNEL_COUNT;
    cfg_wdata <= {30'd0, ch};
    @(posedge clk);
    cur_chans = ch;
    cfg_index <= wmpc_pkg::CFG_DATA_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cur_size = size;
    cfg_wr_en <= 1'b0;
  endtask

  // left-channel word for a new frame; float words lean towards the awkward classes
  function automatic logic [31:0] stim_word(input wmpc_pkg::sample_kind_t k);
    logic [31:0] w;
    w = $urandom;
    if (k != wmpc_pkg::KIND_FLOAT32) return w;
    case ($urandom_range(0, 9))
      0: ;
      1: w[30:23] = 8'($urandom_range(127, 130));
      2: w[30:23] = 8'hFF;
      3: w[30:0] = 31'h7F800000;
      4: w[30:23] = 8'h00;
      5: w[30:23] = 8'($urandom_range(100, 111));
      6: w[30:0] = 31'h3F7FFFFF - 31'($urandom_range(0, 64));
      default: w[30:23] = 8'($urandom_range(112, 126));
    endcase
    return w;
  endfunction

  function automatic logic [7:0] next_stream_byte();
    if (frame_pos == 3'd0) stream_word = stim_word(cur_kind);
    if (frame_pos < 3'd4) return stream_word[frame_pos*8 +: 8];
    return 8'($urandom);
  endfunction

  task automatic test_past_size;
    configure(wmpc_pkg::KIND_PCM16, 2'd1, 32'd0);
    repeat (3) send_byte(8'($urandom));
    drain();
  endtask

  task automatic test_pcm16_extremes;
    configure(wmpc_pkg::KIND_PCM16, 2'd1, bytes_seen + 32'd4);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hA5);
  endtask

  task automatic test_float_specials;
    logic [31:0] words[3];
    words = '{32'h7FC00001, 32'hFF800000, 32'h3F7FFFFF};
    configure(wmpc_pkg::KIND_FLOAT32, 2'd1, bytes_seen + 32'd12);
    foreach (words[i])
      for (int j = 0; j < 4; j++) send_byte(words[i][j*8 +: 8]);
  endtask

  // stereo pcm24 via the out-of-range channel code, then a frame cut short by the size
  task automatic test_pcm24_partial_frame;
    configure(wmpc_pkg::KIND_PCM24, 2'd3, bytes_seen + 32'd8);
    for (int j = 0; j < 8; j++) send_byte(8'($urandom));
  endtask

  task automatic run_segment;
    wmpc_pkg::sample_kind_t k;
    logic [1:0]   ch;
    int unsigned  frame_len, n, extra, pick;
    k = wmpc_pkg::sample_kind_t'($urandom_range(0, 3));
    ch = 2'($urandom_range(0, 3));
    frame_len = sample_bytes(k) * channel_total(ch);
    n = $urandom_range(1, 10) * frame_len;
    extra = 0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: size at or below what has already gone past
      configure(k, ch, 32'($urandom_range(0, bytes_seen)));
      n = $urandom_range(1, 6);
    end else if (pick < 16) begin
      configure(k, ch, 32'hFFFFFFFF);
    end else begin
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame_len - 1);
      if ($urandom_range(0, 4) == 0) extra = $urandom_range(1, 3);
      configure(k, ch, bytes_seen + 32'(n));
    end
    repeat (n + extra) send_byte(next_stream_byte());
  endtask

  task automatic test_random_streams;
    int idle_set[4] = '{0, 72, 0, 13};
    int stall_set[4] = '{0, 0, 72, 13};
    int target;
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      target = counted_items + PHASE_ITEMS;
      while (counted_items < target) run_segment();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_past_size();
    test_pcm16_extremes();
    test_float_specials();
    test_pcm24_partial_frame();
    test_random_streams();
    drain();
    repeat (2 * SETTLE_WAIT) @(posedge clk);
    $display("%0d data bytes converted over all four sample formats and channel codes",
             counted_items);
    $display("%0d samples compared, %0d mismatches", samples_checked, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("wav_to_mono_pcm16_converter_core: match");
    end else begin
      $display("wav_to_mono_pcm16_converter_core: mismatch");
    end
    $finish;
  end

endmodule
